// ===== hw/rtl/delimited_word_packet_aggregator_top_defines.svh =====
// Assertion macros used by the aggregator top module.
// Every property is sampled on the rising clock and is off while reset is applied.
`ifndef DELIMITED_WORD_PACKET_AGGREGATOR_TOP_DEFINES_SVH
`define DELIMITED_WORD_PACKET_AGGREGATOR_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define DWPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define DWPA_NEVER(label, cond, msg) \
  `DWPA_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/dwpa_pkg.sv =====
package dwpa_pkg;

  localparam int unsigned BufferDepthDefault = 256;

  localparam int unsigned CountW   = 9;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CountW-1:0] CountMax = 9'd511;

  localparam logic [ByteW-1:0] CloseThresholdReset = 8'd200;
  localparam logic [ByteW-1:0] MaxPacketLenReset   = 8'd240;
  localparam logic [ByteW-1:0] DelimiterReset      = 8'd36;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLOSE_THRESHOLD = 2'd0,
    REG_MAX_PACKET_LEN  = 2'd1,
    REG_DELIMITER_BYTE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ByteW-1:0] rx_byte;
    logic             framing_error;
    logic             read_buffer;
    logic [ByteW-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic             buffer_index;
    logic [ByteW-1:0] packet_length;
    logic             too_long;
    logic [ByteW-1:0] read_data;
  } out_item_t;

  // A result in flight, before the byte store has returned read data.
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic             buffer_index;
    logic [ByteW-1:0] packet_length;
    logic             too_long;
  } stage_t;

endpackage

// ===== hw/rtl/dwpa_ram.sv =====
module dwpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dwpa_fill.sv =====
module dwpa_fill import dwpa_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CfgIdxW-1:0]                  cfg_idx_i,
  input  logic [ByteW-1:0]                    cfg_data_i,
  input  logic                                accept_i,
  input  in_item_t                            item_i,
  output logic                                mem_we_o,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0]   mem_waddr_o,
  output logic [ByteW-1:0]                    mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0]   mem_raddr_o,
  output stage_t                              result_o
);

  localparam int unsigned AddrW = $clog2(2*BUFFER_DEPTH);
  localparam int unsigned PosW  = $clog2(BUFFER_DEPTH);
  localparam logic [CountW-1:0] LastSlot  = CountW'(BUFFER_DEPTH - 1);
  localparam logic [CountW-1:0] DepthCnt  = CountW'(BUFFER_DEPTH);
  localparam logic [AddrW-1:0]  BufOffset = AddrW'(BUFFER_DEPTH);

  logic [ByteW-1:0]  thresh_q, max_len_q, delim_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              buf_q, buf_d;
  logic              creq_q, creq_d;
  logic              ovf_q, ovf_d;

  logic [CountW-1:0] cnt_inc, wpos9, rpos9;
  logic              ovf_next, is_delim, do_close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= CloseThresholdReset;
      max_len_q <= MaxPacketLenReset;
      delim_q   <= DelimiterReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CLOSE_THRESHOLD: thresh_q  <= cfg_data_i;
        REG_MAX_PACKET_LEN:  max_len_q <= cfg_data_i;
        REG_DELIMITER_BYTE:  delim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      buf_q  <= 1'b1;
      creq_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      buf_q  <= buf_d;
      creq_q <= creq_d;
      ovf_q  <= ovf_d;
    end
  end

  // Bytes past the end of the buffer all land in the last slot.
  assign wpos9 = (cnt_q > LastSlot) ? LastSlot : cnt_q;
  assign rpos9 = ({1'b0, item_i.read_index} > LastSlot) ? LastSlot
                                                        : {1'b0, item_i.read_index};

  assign mem_waddr_o = AddrW'(wpos9[PosW-1:0]) + (buf_q ? BufOffset : '0);
  assign mem_raddr_o = AddrW'(rpos9[PosW-1:0]) + (item_i.read_buffer ? BufOffset : '0);
  assign mem_wdata_o = item_i.rx_byte;

  assign cnt_inc  = (cnt_q == CountMax) ? CountMax : cnt_q + 1'b1;
  assign ovf_next = ovf_q || (cnt_inc >= DepthCnt);
  assign is_delim = (item_i.rx_byte == delim_q);
  assign do_close = (cnt_inc >= {1'b0, thresh_q}) || creq_q;

  always_comb begin
    cnt_d    = cnt_q;
    buf_d    = buf_q;
    creq_d   = creq_q;
    ovf_d    = ovf_q;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    result_o = '0;
    if (accept_i) begin
      case (cmd_e'(item_i.cmd))
        CMD_CLOSE: begin
          creq_d = 1'b1;
        end
        CMD_READ: begin
          mem_re_o        = 1'b1;
          result_o.valid  = 1'b1;
          result_o.kind   = KIND_READ;
        end
        CMD_BYTE: begin
          if (!item_i.framing_error) begin
            mem_we_o = 1'b1;
            cnt_d    = cnt_inc;
            ovf_d    = ovf_next;
            if (is_delim && do_close) begin
              result_o.valid         = 1'b1;
              result_o.kind          = KIND_PACKET;
              result_o.buffer_index  = buf_q;
              result_o.packet_length = (cnt_inc > CountW'(255)) ? 8'd255
                                                                : cnt_inc[ByteW-1:0];
              result_o.too_long      = ovf_next || (cnt_inc > {1'b0, max_len_q});
              buf_d  = ~buf_q;
              cnt_d  = '0;
              creq_d = 1'b0;
              ovf_d  = 1'b0;
            end else if (!is_delim && (cnt_inc >= DepthCnt)) begin
              // The buffer ran full without a delimiter, so it starts over.
              cnt_d = '0;
              ovf_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/delimited_word_packet_aggregator_top.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
// cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One beat is taken per cycle while the input is not stalled; each result passes through the stage register,
// captured alongside the registered read of the byte store, and then through the output register.
// Reset clears the fill state and loads the register defaults; the byte store is not cleared.
// A stalled output holds one result in the output register and one in the stage before it;
// input stalls only when both are full.
`include "delimited_word_packet_aggregator_top_defines.svh"

module delimited_word_packet_aggregator_top import dwpa_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  localparam int unsigned AddrW = $clog2(2*BUFFER_DEPTH);

  logic             accept, s1_adv;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [ByteW-1:0] mem_wdata, mem_rdata;
  stage_t           result;
  stage_t           s1_q, s1_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_is_read, out_pkt_set;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_q.valid && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  dwpa_fill #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_fill (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .result_o    (result)
  );

  dwpa_ram #(
    .Width(ByteW),
    .Depth(2*BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The store's read register only changes on a read, so it holds while this stage waits.
  // An empty stage takes a new beat even while the output register is stalled.
  always_comb begin
    s1_d        = s1_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (s1_adv || !s1_q.valid) begin
      s1_d       = result;
      s1_d.valid = accept && result.valid;
    end
    if (s1_adv) begin
      out_valid_d            = s1_q.valid;
      out_d.kind             = s1_q.kind;
      out_d.buffer_index     = s1_q.buffer_index;
      out_d.packet_length    = s1_q.packet_length;
      out_d.too_long         = s1_q.too_long;
      out_d.read_data        = (s1_q.kind == KIND_READ) ? mem_rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      s1_q        <= s1_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign out_is_read = out_valid_q && (out_q.kind == KIND_READ);
  assign out_pkt_set = out_q.buffer_index || out_q.too_long || (out_q.packet_length != '0);

  `DWPA_NEVER(a_no_rw_same_cycle, mem_we && mem_re, "byte store read and write in one cycle")
  `DWPA_ASSERT(a_stall_needs_full, in_stall_o |-> (s1_q.valid && out_valid_q), "stall with room")
  `DWPA_ASSERT(a_s1_holds, (s1_q.valid && !s1_adv) |=> $stable(s1_q), "held stage changed")
  `DWPA_NEVER(a_read_fields, out_is_read && out_pkt_set, "read result carries packet fields")

endmodule

// ===== test/testbench.sv =====
module testbench import dwpa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = BufferDepthDefault;
  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 4;
  localparam int ItemW = $bits(in_item_t);
  localparam logic [1:0] CmdUnused = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  reg_idx_e   cfg_idx = REG_CLOSE_THRESHOLD;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  // Shadow of the aggregator state.
  logic [ByteW-1:0]  stored_bytes [2*Depth];
  bit                written_slot [2*Depth];
  logic [CountW-1:0] fill_count = '0;
  bit                fill_bank = 1'b1;
  bit                close_pending = 1'b0;
  bit                overflow_seen = 1'b0;
  logic [7:0]        threshold_reg = CloseThresholdReset;
  logic [7:0]        max_len_reg = MaxPacketLenReset;
  logic [7:0]        delimiter_reg = DelimiterReset;

  out_item_t expected_results[$];
  out_item_t oldest_result;
  int        failures = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;

  delimited_word_packet_aggregator_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver; a requested hold-off overrides the random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int slot_index(bit bank, int pos);
    if (pos > Depth - 1) pos = Depth - 1;
    return (bank ? Depth : 0) + pos;
  endfunction

  function automatic void predict_packet(in_item_t it);
    out_item_t res;
    int slot;
    res = '0;
    case (it.cmd)
      CMD_CLOSE: close_pending = 1'b1;
      CMD_READ: begin
        res.kind = KIND_READ;
        res.read_data = stored_bytes[slot_index(it.read_buffer, int'(it.read_index))];
        expected_results.push_back(res);
      end
      CMD_BYTE: begin
        if (!it.framing_error) begin
          slot = slot_index(fill_bank, int'(fill_count));
          stored_bytes[slot] = it.rx_byte;
          written_slot[slot] = 1'b1;
          if (fill_count != CountMax) fill_count++;
          if (fill_count >= Depth) overflow_seen = 1'b1;
          if (it.rx_byte == delimiter_reg) begin
            if (fill_count >= threshold_reg || close_pending) begin
              res.kind = KIND_PACKET;
              res.buffer_index = fill_bank;
              res.packet_length = (fill_count > 255) ? 8'd255 : fill_count[7:0];
              res.too_long = overflow_seen || (fill_count > max_len_reg);
              expected_results.push_back(res);
              fill_bank = ~fill_bank;
              fill_count = '0;
              close_pending = 1'b0;
              overflow_seen = 1'b0;
            end
          end else if (fill_count >= Depth) begin
            // Ran off the end without a delimiter: the same buffer starts over.
            fill_count = '0;
            overflow_seen = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: %p", out_item);
        failures++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("kind", 8'(oldest_result.kind), 8'(out_item.kind));
        check_field("buffer_index", 8'(oldest_result.buffer_index), 8'(out_item.buffer_index));
        check_field("packet_length", oldest_result.packet_length, out_item.packet_length);
        check_field("too_long", 8'(oldest_result.too_long), 8'(out_item.too_long));
        check_field("read_data", oldest_result.read_data, out_item.read_data);
      end
    end
  end

  task automatic send_beat(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_packet(it);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it = in_item_t'(ItemW'($urandom));
    return it;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == delimiter_reg) b = ~b;
    return b;
  endfunction

  task automatic send_byte(logic [7:0] data);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_BYTE;
    it.rx_byte = data;
    it.framing_error = 1'b0;
    send_beat(it);
  endtask

  task automatic send_close_request();
    in_item_t it;
    it = random_item();
    it.cmd = CMD_CLOSE;
    send_beat(it);
  endtask

  task automatic send_read(bit bank, logic [7:0] idx);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_READ;
    it.read_buffer = bank;
    it.read_index = idx;
    send_beat(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] value);
    wait_drained();
    // A beat without a result may still be in the pipeline.
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_CLOSE_THRESHOLD: threshold_reg = value;
      REG_MAX_PACKET_LEN:  max_len_reg = value;
      REG_DELIMITER_BYTE:  delimiter_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] threshold, logic [7:0] max_len, logic [7:0] delim);
    write_reg(REG_CLOSE_THRESHOLD, threshold);
    write_reg(REG_MAX_PACKET_LEN, max_len);
    write_reg(REG_DELIMITER_BYTE, delim);
  endtask

  task automatic test_directed();
    in_item_t it;
    send_byte(8'h00);
    send_byte(8'hFF);
    it = random_item();
    it.cmd = CMD_BYTE;
    it.framing_error = 1'b1;
    send_beat(it);
    it = random_item();
    it.cmd = CmdUnused;
    send_beat(it);
    // Below the threshold a delimiter is just another byte.
    send_byte(delimiter_reg);
    send_close_request();
    send_byte(delimiter_reg);
    send_read(1'b1, 8'd0);
    send_read(1'b1, 8'd1);
    send_read(1'b1, 8'd3);
    set_config(8'd1, 8'd0, 8'h00);
    send_byte(8'h00);
    write_reg(REG_DELIMITER_BYTE, 8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_read(1'b0, 8'd0);
  endtask

  task automatic test_overflow();
    set_config(8'd255, 8'd255, DelimiterReset);
    send_close_request();
    send_byte(delimiter_reg);
    // No delimiter before the end: the buffer restarts and every slot of that buffer gets written.
    repeat (Depth) send_byte(plain_byte());
    send_close_request();
    send_byte(delimiter_reg);
    // A delimiter landing in the last slot closes a packet flagged too long.
    repeat (Depth - 1) send_byte(plain_byte());
    send_byte(delimiter_reg);
    send_read(1'b0, 8'd0);
    send_read(1'b0, 8'd255);
    send_read(1'b1, 8'd0);
    send_read(1'b1, 8'd255);
  endtask

  task automatic send_traffic(int items);
    in_item_t it;
    int sent;
    int roll;
    int len;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 68) begin
        len = $urandom_range(24);
        repeat (len) send_byte(plain_byte());
        if ($urandom_range(1)) begin
          send_close_request();
          sent++;
        end
        send_byte(delimiter_reg);
        sent += len + 1;
      end else if (roll < 84) begin
        it = random_item();
        it.cmd = CMD_READ;
        if (written_slot[slot_index(it.read_buffer, int'(it.read_index))]) begin
          send_beat(it);
          sent++;
        end
      end else if (roll < 93) begin
        it = random_item();
        it.cmd = CMD_BYTE;
        send_beat(it);
        if (!it.framing_error) sent++;
      end else if (roll < 97) begin
        send_close_request();
        sent++;
      end else begin
        it = random_item();
        it.cmd = CmdUnused;
        send_beat(it);
      end
    end
  endtask

  task automatic test_random(int items, int idle_pct, int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    send_traffic(items);
  endtask

  task automatic test_pressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 80;
    send_traffic(40);
    // Let the block run empty before going on.
    wait_drained();
    send_traffic(20);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_overflow();
    set_config(8'($urandom_range(4, 16)), 8'($urandom_range(6, 20)), DelimiterReset);
    test_random(25, 0, 0);
    set_config(8'd1, 8'd0, 8'h00);
    test_random(25, 62, 0);
    set_config(8'($urandom_range(4, 16)), 8'd255, 8'hFF);
    test_random(25, 0, 62);
    set_config(8'($urandom_range(1, 255)), 8'($urandom_range(6, 20)), 8'($urandom_range(255)));
    test_random(25, 12, 12);
    set_config(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(255)));
    test_pressure();

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dwpa_pkg.sv
hw/rtl/dwpa_ram.sv
hw/rtl/dwpa_fill.sv
hw/rtl/delimited_word_packet_aggregator_top.sv
test/testbench.sv
